// File: src/pks_pkg.sv
// Package: shared types, operation codes and the ordering function of the sorter.
`timescale 1ns / 1ps
package pks_pkg;

  // One record as held in a cell of the chain.
  typedef struct packed {
    logic signed [15:0] len;
    logic signed [15:0] wgt;
  } rec_t;

  // What every cell of the chain does in the current cycle.
  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_PUSH = 2'd1,
    OP_SORT = 2'd2,
    OP_POP  = 2'd3
  } cell_op_t;

  // Control word broadcast from the sequencer to all cells.
  typedef struct packed {
    cell_op_t op;
    logic     phase;
    logic     order;
  } ctl_t;

  // True if record a must stand strictly after record b.
  // order = 1: length then weight; order = 0: weight then length.
  function automatic logic goes_after(input rec_t a, input rec_t b, input logic order);
    logic signed [15:0] ap;
    logic signed [15:0] bp;
    logic signed [15:0] as_k;
    logic signed [15:0] bs_k;
    ap   = order ? a.len : a.wgt;
    bp   = order ? b.len : b.wgt;
    as_k = order ? a.wgt : a.len;
    bs_k = order ? b.wgt : b.len;
    if (ap != bp) begin
      return ap > bp;
    end
    return as_k > bs_k;
  endfunction

endpackage

// File: src/pks_in_if.sv
// Interface: input channel carrying load and end words.
`timescale 1ns / 1ps
interface pks_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [15:0] stick_length;
  logic signed [15:0] stick_weight;

  modport source (output valid, output kind, output stick_length, output stick_weight,
                  input ready);
  modport sink (input valid, input kind, input stick_length, input stick_weight,
                output ready);
endinterface

// File: src/pks_out_if.sv
// Interface: result channel carrying sorted records and their flags.
`timescale 1ns / 1ps
interface pks_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_length;
  logic signed [15:0] out_weight;
  logic [5:0]         descent_count;
  logic               overflow;
  logic               empty_set;
  logic               last;

  modport source (output valid, output out_length, output out_weight, output descent_count,
                  output overflow, output empty_set, output last, input ready);
  modport sink (input valid, input out_length, input out_weight, input descent_count,
                input overflow, input empty_set, input last, output ready);
endinterface

// File: src/pair_key_insertion_sorter_top.sv
// Top level: record sorter built from a chain of compare-exchange cells.
//
//  Port      Dir  Handshake     Word
//  in_ch     in   valid/ready   kind, stick_length, stick_weight
//  out_ch    out  valid/ready   out_length, out_weight, descent_count, overflow,
//                               empty_set, last
//  cfg_*     in   write enable  key_order (1 bit)
//
// A load word enters the head cell and the chain shifts up by one.
// An end word starts as many odd-even exchange passes as there are stored records,
// then one result per cycle while out_ch is not stalled is shifted out of the head cell through the output register.
// Input is held off from the end word until the last result has been loaded.
// Reset (rst_n, synchronous) empties the chain, clears the overflow flag and output valid, and sets key_order to 1.
// A stall on out_ch holds the chain and the output register.
`timescale 1ns / 1ps
module pair_key_insertion_sorter_top #(
  parameter int MAX_RECORDS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  pks_in_if.sink    in_ch,
  pks_out_if.source out_ch,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data
);
  import pks_pkg::*;

  localparam int CNT_W = $clog2(MAX_RECORDS + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SORT = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   pass_r, pass_nxt;
  logic               ovf_r, ovf_nxt;
  logic               order_r, order_nxt;
  logic               key_order_r;
  logic [5:0]         desc_r, desc_nxt;
  logic signed [15:0] prev_sec_r, prev_sec_nxt;
  logic               first_r, first_nxt;

  logic               out_valid_r, out_valid_nxt;
  rec_t               out_rec_r, out_rec_nxt;
  logic [5:0]         out_desc_r, out_desc_nxt;
  logic               out_ovf_r, out_ovf_nxt;
  logic               out_empty_r, out_empty_nxt;
  logic               out_last_r, out_last_nxt;

  ctl_t               ctl;
  rec_t               push_rec;
  rec_t               head_rec;
  logic               head_vld;
  logic               in_fire;
  logic               emit_fire;
  logic signed [15:0] head_sec;
  logic               descent;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign emit_fire   = (state_r == ST_EMIT) && (!out_valid_r || out_ch.ready);

  assign push_rec.len = in_ch.stick_length;
  assign push_rec.wgt = in_ch.stick_weight;

  // Secondary key of the head record and descent against the previous word.
  assign head_sec = order_r ? head_rec.wgt : head_rec.len;
  assign descent  = !first_r && (head_sec < prev_sec_r);

  // Sequencer: loads, sort passes and emission.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pass_nxt      = pass_r;
    ovf_nxt       = ovf_r;
    order_nxt     = order_r;
    desc_nxt      = desc_r;
    prev_sec_nxt  = prev_sec_r;
    first_nxt     = first_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_rec_nxt   = out_rec_r;
    out_desc_nxt  = out_desc_r;
    out_ovf_nxt   = out_ovf_r;
    out_empty_nxt = out_empty_r;
    out_last_nxt  = out_last_r;
    ctl.op        = OP_HOLD;
    ctl.phase     = pass_r[0];
    ctl.order     = order_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (!in_ch.kind) begin
            if (count_r < CNT_W'(MAX_RECORDS)) begin
              ctl.op    = OP_PUSH;
              count_nxt = count_r + 1'b1;
            end else begin
              ovf_nxt = 1'b1;
            end
          end else begin
            order_nxt = key_order_r;
            pass_nxt  = '0;
            desc_nxt  = '0;
            first_nxt = 1'b1;
            state_nxt = (count_r == '0) ? ST_EMIT : ST_SORT;
          end
        end
      end
      ST_SORT: begin
        ctl.op   = OP_SORT;
        pass_nxt = pass_r + 1'b1;
        if (pass_r == count_r - 1'b1) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_fire) begin
          out_valid_nxt = 1'b1;
          out_ovf_nxt   = ovf_r;
          if (count_r == '0) begin
            out_rec_nxt   = '0;
            out_desc_nxt  = '0;
            out_empty_nxt = 1'b1;
            out_last_nxt  = 1'b1;
            ovf_nxt       = 1'b0;
            state_nxt     = ST_IDLE;
          end else begin
            ctl.op        = OP_POP;
            out_rec_nxt   = head_rec;
            out_desc_nxt  = desc_r + 6'(descent);
            out_empty_nxt = 1'b0;
            out_last_nxt  = (count_r == CNT_W'(1));
            desc_nxt      = desc_r + 6'(descent);
            prev_sec_nxt  = head_sec;
            first_nxt     = 1'b0;
            count_nxt     = count_r - 1'b1;
            if (count_r == CNT_W'(1)) begin
              ovf_nxt   = 1'b0;
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State, count, overflow, key order and output valid are reset; the other registers are not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      key_order_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        key_order_r <= cfg_wr_data;
      end
    end
    pass_r      <= pass_nxt;
    order_r     <= order_nxt;
    desc_r      <= desc_nxt;
    prev_sec_r  <= prev_sec_nxt;
    first_r     <= first_nxt;
    out_rec_r   <= out_rec_nxt;
    out_desc_r  <= out_desc_nxt;
    out_ovf_r   <= out_ovf_nxt;
    out_empty_r <= out_empty_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Record chain.
  pks_chain #(
    .DEPTH (MAX_RECORDS)
  ) u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .push_rec (push_rec),
    .head_rec (head_rec),
    .head_vld (head_vld)
  );

  // Result channel.
  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_length    = out_rec_r.len;
  assign out_ch.out_weight    = out_rec_r.wgt;
  assign out_ch.descent_count = out_desc_r;
  assign out_ch.overflow      = out_ovf_r;
  assign out_ch.empty_set     = out_empty_r;
  assign out_ch.last          = out_last_r;

  // The fill count never passes the chain length.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_RECORDS))
    else $error("record count beyond chain length");

  // Emission only ever reads a head cell that holds a record.
  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_fire && count_r != '0) |-> head_vld)
    else $error("emission from an empty head cell");

  // Issuing the final word of a run returns the sequencer to idle with the set cleared.
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_fire && (count_r == '0 || count_r == CNT_W'(1)))
      |=> (state_r == ST_IDLE && count_r == '0 && !ovf_r && out_valid_r && out_last_r))
    else $error("run did not end cleanly");

  // An empty-set word carries zero record fields and closes the run.
  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_empty_r)
      |-> (out_last_r && out_rec_r == '0 && out_desc_r == '0))
    else $error("malformed empty-set word");

endmodule

// File: src/pks_cell.sv
// Cell: holds one record and its valid bit, and exchanges with its neighbours.
`timescale 1ns / 1ps
module pks_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  pks_pkg::ctl_t ctl,
  input  logic          cell_parity,
  input  pks_pkg::rec_t left_rec,
  input  logic          left_vld,
  input  logic          left_swap,
  input  pks_pkg::rec_t right_rec,
  input  logic          right_vld,
  output logic          swap,
  output pks_pkg::rec_t rec,
  output logic          vld
);
  import pks_pkg::*;

  rec_t rec_r;
  rec_t rec_nxt;
  logic vld_r;
  logic vld_nxt;

  // This cell leads the pair with its right neighbour in the matching phase.
  assign swap = (ctl.op == OP_SORT) && (ctl.phase == cell_parity) && vld_r && right_vld &&
                goes_after(rec_r, right_rec, ctl.order);

  // Next contents: shift up on load, exchange on sort, shift down on emission.
  always_comb begin
    rec_nxt = rec_r;
    vld_nxt = vld_r;
    case (ctl.op)
      OP_PUSH: begin
        rec_nxt = left_rec;
        vld_nxt = left_vld;
      end
      OP_SORT: begin
        if (swap) begin
          rec_nxt = right_rec;
        end else if (left_swap) begin
          rec_nxt = left_rec;
        end
      end
      OP_POP: begin
        rec_nxt = right_rec;
        vld_nxt = right_vld;
      end
      default: begin
        rec_nxt = rec_r;
        vld_nxt = vld_r;
      end
    endcase
  end

  // Record payload needs no reset; the valid bit does.
  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign rec = rec_r;
  assign vld = vld_r;

endmodule

// File: src/pks_chain.sv
// Chain: a row of record cells with neighbour links.
`timescale 1ns / 1ps
module pks_chain #(
  parameter int DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  pks_pkg::ctl_t ctl,
  input  pks_pkg::rec_t push_rec,
  output pks_pkg::rec_t head_rec,
  output logic          head_vld
);
  import pks_pkg::*;

  rec_t           recs  [DEPTH];
  logic [DEPTH-1:0] vlds;
  logic [DEPTH-1:0] swaps;

  // Each cell links to the one before and the one after it.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    rec_t lrec;
    logic lvld;
    logic lswp;
    rec_t rrec;
    logic rvld;

    if (i == 0) begin : g_first
      assign lrec = push_rec;
      assign lvld = 1'b1;
      assign lswp = 1'b0;
    end else begin : g_mid
      assign lrec = recs[i-1];
      assign lvld = vlds[i-1];
      assign lswp = swaps[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign rrec = '0;
      assign rvld = 1'b0;
    end else begin : g_inner
      assign rrec = recs[i+1];
      assign rvld = vlds[i+1];
    end

    pks_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .cell_parity (1'(i % 2)),
      .left_rec    (lrec),
      .left_vld    (lvld),
      .left_swap   (lswp),
      .right_rec   (rrec),
      .right_vld   (rvld),
      .swap        (swaps[i]),
      .rec         (recs[i]),
      .vld         (vlds[i])
    );
  end

  assign head_rec = recs[0];
  assign head_vld = vlds[0];

endmodule
